// ----- rtl/hbm_pkg.sv -----
// Shared types and constants for the heartbeat miss monitor.
package hbm_pkg;

  localparam int MAX_ENTRIES_DEF = 8;
  localparam logic [15:0] TICK_DIVIDER_RST = 16'd200;
  localparam logic [7:0] TIMEOUT_COUNT_RST = 8'd3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_INIT   = 3'd1,
    OP_DEINIT = 3'd2,
    OP_ADD    = 3'd3,
    OP_PONG   = 3'd4,
    OP_QUERY  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    KIND_ACK     = 3'd0,
    KIND_PING    = 3'd1,
    KIND_TIMEOUT = 3'd2,
    KIND_NOSLOT  = 3'd3,
    KIND_MISSES  = 3'd4
  } kind_t;

  typedef enum logic {
    REG_TICK_DIVIDER  = 1'b0,
    REG_TIMEOUT_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_TMO,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] instance_id;
    logic [7:0] channel_id;
  } req_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [7:0] out_instance;
    logic [7:0] out_channel;
    logic [7:0] miss_value;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [7:0] instance_id;
    logic [7:0] channel_id;
    logic [7:0] misses;
  } entry_t;

endpackage

// ----- rtl/hbm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// ----- rtl/heartbeat_miss_monitor.sv -----
// Heartbeat miss monitor: channel table, period counter and scan sequencer.
// Flow: an accepted request passes through S_START to S_FINAL, whose result is registered into rsp_valid;
//   a scan visits each slot in S_READ, each used entry in S_EVAL and, on a timeout, S_TMO,
//   and a scan without a match ends with a last S_READ before S_FINAL.
// Throughput: one request at a time; a new request is taken only back in S_IDLE, and a held result stalls.
// Reset clears the control state, used flags and registers; the entry RAM is not cleared.
module heartbeat_miss_monitor
  import hbm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  // result channel
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output rsp_t        rsp,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_ENTRIES);

  // configuration registers
  logic [15:0] tick_divider;
  logic [7:0]  timeout_count;

  // sequencer and table control
  state_t                  state, state_next;
  logic [CNT_W-1:0]        idx;
  logic [IDX_W-1:0]        idx_a;
  logic [2:0]              op_q;
  logic [7:0]              inst_q;
  logic [7:0]              chan_q;
  logic                    active;
  logic [15:0]             period;
  logic [MAX_ENTRIES-1:0]  used;
  logic                    free_found;
  logic [IDX_W-1:0]        free_slot;
  logic                    hit;
  logic [7:0]              hit_misses;
  entry_t                  ent;

  // entry RAM
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_wa;
  entry_t                  ram_wd;
  entry_t                  ram_rd;

  // shared datapath: one compare on the channel id, an increment and compare each for the period and the misses
  logic [16:0]             period_inc;
  logic                    period_wrap;
  logic                    chan_match;
  logic [8:0]              miss_inc;
  logic                    miss_tmo;
  logic [7:0]              miss_new;

  // result slot
  logic                    slot_free;
  logic                    emit;
  rsp_t                    emit_data;
  logic                    idx_step;
  logic                    add_commit;

  assign idx_a = idx[IDX_W-1:0];

  assign period_inc  = {1'b0, period} + 17'd1;
  assign period_wrap = (period_inc >= {1'b0, tick_divider});
  assign chan_match  = (ram_rd.channel_id == chan_q);
  assign miss_inc    = {1'b0, ram_rd.misses} + 9'd1;
  assign miss_tmo    = (miss_inc >= {1'b0, timeout_count});
  assign miss_new    = miss_tmo ? timeout_count : miss_inc[7:0];

  // a held result blocks the sequencer; a taken one frees the slot at once
  assign slot_free = !rsp_valid || rsp_ready;

  hbm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (idx_a),
    .rd  (ram_rd)
  );

  // register port: writes take effect in the access phase
  assign pready = 1'b1;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_TICK_DIVIDER:  prdata = {16'd0, tick_divider};
      REG_TIMEOUT_COUNT: prdata = {24'd0, timeout_count};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider  <= TICK_DIVIDER_RST;
      timeout_count <= TIMEOUT_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_TICK_DIVIDER:  tick_divider  <= pwdata[15:0];
        REG_TIMEOUT_COUNT: timeout_count <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_START;
      end
      S_START: begin
        if (op_q == OP_TICK) begin
          state_next = (active && period_wrap) ? S_READ : S_FINAL;
        end else if (op_q == OP_ADD || op_q == OP_PONG || op_q == OP_QUERY) begin
          state_next = S_READ;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_READ: begin
        if (idx == LAST_CNT) begin
          state_next = S_FINAL;
        end else if (used[idx_a]) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_q == OP_TICK) begin
          if (slot_free) state_next = miss_tmo ? S_TMO : S_READ;
        end else begin
          state_next = chan_match ? S_FINAL : S_READ;
        end
      end
      S_TMO: begin
        if (slot_free) state_next = S_READ;
      end
      S_FINAL: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: result, RAM write, scan step
  always_comb begin
    req_ready  = (state == S_IDLE);
    emit       = 1'b0;
    emit_data  = '0;
    ram_we     = 1'b0;
    ram_wa     = idx_a;
    ram_wd     = ram_rd;
    idx_step   = 1'b0;
    add_commit = 1'b0;
    case (state)
      S_READ: begin
        if (idx != LAST_CNT && !used[idx_a]) idx_step = 1'b1;
      end
      S_EVAL: begin
        if (op_q == OP_TICK) begin
          emit                   = slot_free;
          emit_data.result_kind  = KIND_PING;
          emit_data.out_instance = ram_rd.instance_id;
          emit_data.out_channel  = ram_rd.channel_id;
          ram_we                 = slot_free;
          ram_wd.misses          = miss_new;
          idx_step               = slot_free && !miss_tmo;
        end else if (chan_match) begin
          if (op_q == OP_PONG) begin
            ram_we        = 1'b1;
            ram_wd.misses = 8'd0;
          end
        end else begin
          idx_step = 1'b1;
        end
      end
      S_TMO: begin
        emit                   = slot_free;
        emit_data.result_kind  = KIND_TIMEOUT;
        emit_data.out_instance = ent.instance_id;
        emit_data.out_channel  = ent.channel_id;
        idx_step               = slot_free;
      end
      S_FINAL: begin
        emit           = slot_free;
        emit_data.last = 1'b1;
        case (op_q)
          OP_ADD: begin
            emit_data.out_channel = chan_q;
            if (hit || free_found) begin
              emit_data.result_kind = KIND_ACK;
            end else begin
              emit_data.result_kind = KIND_NOSLOT;
            end
            add_commit = slot_free && !hit && free_found;
            ram_we     = add_commit;
            ram_wa     = free_slot;
            ram_wd     = '{instance_id: inst_q, channel_id: chan_q, misses: timeout_count};
          end
          OP_PONG: begin
            emit_data.result_kind = KIND_ACK;
            emit_data.out_channel = chan_q;
          end
          OP_QUERY: begin
            emit_data.result_kind = KIND_MISSES;
            emit_data.out_channel = chan_q;
            emit_data.miss_value  = hit_misses;
          end
          default: emit_data.result_kind = KIND_ACK;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer, table control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= 1'b0;
      period    <= '0;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;

      // hold the result until the far side takes it
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end

      if (state == S_START) begin
        case (op_q)
          OP_TICK: begin
            if (active) period <= period_wrap ? 16'd0 : period_inc[15:0];
          end
          OP_INIT: begin
            if (!active) begin
              used   <= '0;
              period <= '0;
              active <= 1'b1;
            end
          end
          OP_DEINIT: begin
            used   <= '0;
            active <= 1'b0;
          end
          default: ;
        endcase
      end

      if (add_commit) used[free_slot] <= 1'b1;
    end
  end

  // payload and scan bookkeeping: no reset needed
  always_ff @(posedge clk) begin
    if (emit) rsp <= emit_data;

    if (req_valid && req_ready) begin
      op_q       <= req.op;
      inst_q     <= req.instance_id;
      chan_q     <= req.channel_id;
      idx        <= '0;
      hit        <= 1'b0;
      hit_misses <= 8'd0;
      free_found <= 1'b0;
      free_slot  <= '0;
    end else begin
      if (idx_step) idx <= idx + CNT_W'(1);

      // remember the first free slot on the way for an add
      if (state == S_READ && idx != LAST_CNT && !used[idx_a] && !free_found) begin
        free_found <= 1'b1;
        free_slot  <= idx_a;
      end

      if (state == S_EVAL) begin
        ent <= ram_rd;
        if (op_q != OP_TICK && chan_match) begin
          hit        <= 1'b1;
          hit_misses <= ram_rd.misses;
        end
      end
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the heartbeat miss monitor: directed ops, then random phases.
module tb;
  import hbm_pkg::*;

  localparam int ENTRIES      = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_LIMIT = 10;
  // Op codes the block does not use; they must still be acknowledged.
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req       = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted copy of the monitor: activity, period counter and channel table.
  logic        hb_live;
  logic [15:0] hb_period;
  logic [15:0] cfg_divider;
  logic [7:0]  cfg_timeout;
  logic        slot_used   [ENTRIES];
  logic [7:0]  slot_inst   [ENTRIES];
  logic [7:0]  slot_chan   [ENTRIES];
  logic [7:0]  slot_misses [ENTRIES];

  // Results owed by the block, oldest first.
  rsp_t pending_results[$];

  // Run bookkeeping.
  bit steady = 1'b0;  // when set, neither side idles
  int mismatches = 0;
  int n_requests = 0;
  int n_results = 0;
  int n_pings = 0;
  int n_timeouts = 0;
  int n_settings = 0;
  int cycle_count = 0;

  heartbeat_miss_monitor DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #2 clk = ~clk;

  // Stall the result channel about 27 percent of the time, unless in a steady stretch.
  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(99) >= 27);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: no progress after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void owe_result(input kind_t kind, input logic [7:0] inst,
                                     input logic [7:0] chan, input logic [7:0] miss,
                                     input logic last);
    rsp_t r;
    r.result_kind  = kind;
    r.out_instance = inst;
    r.out_channel  = chan;
    r.miss_value   = miss;
    r.last         = last;
    pending_results.push_back(r);
  endfunction

  function automatic void monitor_reset();
    int i;
    hb_live     = 1'b0;
    hb_period   = '0;
    cfg_divider = TICK_DIVIDER_RST;
    cfg_timeout = TIMEOUT_COUNT_RST;
    for (i = 0; i < ENTRIES; i++) begin
      slot_used[i]   = 1'b0;
      slot_inst[i]   = '0;
      slot_chan[i]   = '0;
      slot_misses[i] = '0;
    end
  endfunction

  // Apply one accepted request to the predicted state and queue what it must return.
  function automatic void predict_monitor(input req_t r);
    int          i;
    int          hit;
    int          spare;
    logic [16:0] nxt;
    logic [8:0]  m;
    hit   = -1;
    spare = -1;
    for (i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_chan[i] == r.channel_id) hit = i;
      if (spare < 0 && !slot_used[i]) spare = i;
    end
    case (r.op)
      OP_TICK: begin
        if (hb_live) begin
          nxt = {1'b0, hb_period} + 17'd1;
          // A divider of zero, or one lowered below the count, ends the period at once.
          if (nxt >= {1'b0, cfg_divider}) begin
            hb_period = '0;
            for (i = 0; i < ENTRIES; i++) begin
              if (slot_used[i]) begin
                owe_result(KIND_PING, slot_inst[i], slot_chan[i], 8'h00, 1'b0);
                // Nine bits so a count of 255 cannot wrap; hold at the threshold.
                m = {1'b0, slot_misses[i]} + 9'd1;
                if (m >= {1'b0, cfg_timeout}) begin
                  owe_result(KIND_TIMEOUT, slot_inst[i], slot_chan[i], 8'h00, 1'b0);
                  m = {1'b0, cfg_timeout};
                end
                slot_misses[i] = m[7:0];
              end
            end
          end else begin
            hb_period = nxt[15:0];
          end
        end
        owe_result(KIND_ACK, 8'h00, 8'h00, 8'h00, 1'b1);
      end
      OP_INIT: begin
        if (!hb_live) begin
          for (i = 0; i < ENTRIES; i++) begin
            slot_used[i]   = 1'b0;
            slot_inst[i]   = '0;
            slot_chan[i]   = '0;
            slot_misses[i] = '0;
          end
          hb_period = '0;
          hb_live   = 1'b1;
        end
        owe_result(KIND_ACK, 8'h00, 8'h00, 8'h00, 1'b1);
      end
      OP_DEINIT: begin
        // Only the used flags go; the stale fields stay behind.
        for (i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
        hb_live = 1'b0;
        owe_result(KIND_ACK, 8'h00, 8'h00, 8'h00, 1'b1);
      end
      OP_ADD: begin
        if (hit < 0 && spare < 0) begin
          owe_result(KIND_NOSLOT, 8'h00, r.channel_id, 8'h00, 1'b1);
        end else begin
          if (hit < 0) begin
            slot_inst[spare]   = r.instance_id;
            slot_chan[spare]   = r.channel_id;
            slot_misses[spare] = cfg_timeout;
            slot_used[spare]   = 1'b1;
          end
          owe_result(KIND_ACK, 8'h00, r.channel_id, 8'h00, 1'b1);
        end
      end
      OP_PONG: begin
        if (hit >= 0) slot_misses[hit] = '0;
        owe_result(KIND_ACK, 8'h00, r.channel_id, 8'h00, 1'b1);
      end
      OP_QUERY: begin
        owe_result(KIND_MISSES, 8'h00, r.channel_id,
                   (hit >= 0) ? slot_misses[hit] : 8'h00, 1'b1);
      end
      default: begin
        owe_result(KIND_ACK, 8'h00, 8'h00, 8'h00, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every result transfer is matched against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      n_results++;
      if (rsp.result_kind == KIND_PING) n_pings++;
      if (rsp.result_kind == KIND_TIMEOUT) n_timeouts++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("tb: unexpected result kind %0d chan %02h at cycle %0d",
                   rsp.result_kind, rsp.out_channel, cycle_count);
      end else begin
        want = pending_results.pop_front();
        if (rsp.result_kind !== want.result_kind || rsp.out_instance !== want.out_instance ||
            rsp.out_channel !== want.out_channel || rsp.miss_value !== want.miss_value ||
            rsp.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"tb: result %0d differs (expected/actual): kind %0d/%0d ",
                      "inst %02h/%02h chan %02h/%02h miss %0d/%0d last %0b/%0b"},
                     n_results, want.result_kind, rsp.result_kind, want.out_instance,
                     rsp.out_instance, want.out_channel, rsp.out_channel, want.miss_value,
                     rsp.miss_value, want.last, rsp.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side and register port
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(input logic [2:0] op, input logic [7:0] inst,
                                    input logic [7:0] chan);
    req_t r;
    r.op          = op;
    r.instance_id = inst;
    r.channel_id  = chan;
    return r;
  endfunction

  // Send one request; valid is left high so back-to-back transfers need no gap.
  task automatic send_request(input req_t r);
    if (!steady && $urandom_range(99) < 27) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    n_requests++;
    predict_monitor(r);
  endtask

  // Drop valid and hold off until every owed result has been seen.
  task automatic settle_block();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic read_register(input reg_idx_t idx, input logic [15:0] want);
    logic [15:0] mask;
    logic [15:0] got;
    mask    = (idx == REG_TICK_DIVIDER) ? 16'hFFFF : 16'h00FF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata[15:0] & mask;
    if (got !== (want & mask)) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("tb: register %0d reads %04h, expected %04h", idx, got, want & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Setup and access cycle, then read the register back.
  task automatic write_register(input reg_idx_t idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_TICK_DIVIDER) cfg_divider = value;
    else cfg_timeout = value[7:0];
    read_register(idx, value);
  endtask

  task automatic set_thresholds(input logic [15:0] divider, input logic [7:0] timeout);
    settle_block();
    write_register(REG_TICK_DIVIDER, divider);
    write_register(REG_TIMEOUT_COUNT, {8'h00, timeout});
    n_settings++;
  endtask

  // Mostly well-formed traffic: channels drawn from a pool a little larger than the
  // table so lookups hit and the table fills, with some arbitrary ids and odd ops.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    pick          = $urandom_range(99);
    r.instance_id = 8'($urandom_range(255));
    r.channel_id  = ($urandom_range(99) < 80) ? 8'($urandom_range(11)) : 8'($urandom_range(255));
    if (pick < 42) r.op = OP_TICK;
    else if (pick < 60) r.op = OP_ADD;
    else if (pick < 72) r.op = OP_PONG;
    else if (pick < 86) r.op = OP_QUERY;
    else if (pick < 90) r.op = OP_INIT;
    else if (pick < 94) r.op = OP_DEINIT;
    else if (pick < 97) r.op = OP_SPARE6;
    else r.op = OP_SPARE7;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_defaults();
    read_register(REG_TICK_DIVIDER, TICK_DIVIDER_RST);
    read_register(REG_TIMEOUT_COUNT, {8'h00, TIMEOUT_COUNT_RST});
  endtask

  // Every op but DEINIT, with the inactive, duplicate, unknown and spare cases.
  task automatic test_basic_ops();
    send_request(make_req(OP_TICK, 8'hFF, 8'hFF));    // inactive: ack only
    send_request(make_req(OP_ADD, 8'hFF, 8'h00));     // add acts while inactive
    send_request(make_req(OP_INIT, 8'h00, 8'h00));    // clears that entry again
    send_request(make_req(OP_INIT, 8'h00, 8'h00));    // already active: no change
    send_request(make_req(OP_ADD, 8'hFF, 8'h00));
    send_request(make_req(OP_ADD, 8'h00, 8'hFF));
    send_request(make_req(OP_ADD, 8'h55, 8'h00));     // already present
    send_request(make_req(OP_QUERY, 8'h00, 8'h00));
    send_request(make_req(OP_PONG, 8'hAA, 8'h00));
    send_request(make_req(OP_QUERY, 8'h00, 8'h00));
    send_request(make_req(OP_QUERY, 8'h00, 8'h5A));   // unknown channel
    send_request(make_req(OP_PONG, 8'h00, 8'h5A));
    send_request(make_req(OP_SPARE6, 8'hFF, 8'hFF));
    send_request(make_req(OP_SPARE7, 8'hFF, 8'hFF));
  endtask

  // Fill the table, overflow it, and scan it with the timeout at its top value.
  task automatic test_full_table();
    set_thresholds(16'd1, 8'd255);
    send_request(make_req(OP_ADD, 8'h01, 8'h81));
    send_request(make_req(OP_ADD, 8'h02, 8'h42));
    send_request(make_req(OP_ADD, 8'h04, 8'h24));
    send_request(make_req(OP_ADD, 8'h08, 8'h18));
    send_request(make_req(OP_ADD, 8'h10, 8'h7E));
    send_request(make_req(OP_ADD, 8'h80, 8'h33));
    send_request(make_req(OP_ADD, 8'h7F, 8'h99));     // no free slot
    send_request(make_req(OP_TICK, 8'h00, 8'h00));    // full scan: pings and timeouts
    send_request(make_req(OP_QUERY, 8'h00, 8'h81));   // held at 255
    send_request(make_req(OP_DEINIT, 8'h00, 8'h00));
  endtask

  task automatic run_random_phase(input logic [15:0] divider, input logic [7:0] timeout,
                                  input int count, input bit calm);
    int i;
    set_thresholds(divider, timeout);
    steady = calm;
    send_request(make_req(OP_INIT, 8'h00, 8'h00));
    for (i = 1; i < count; i++) begin
      // Now and then let the block run dry before the next transfer.
      if ($urandom_range(99) < 3) settle_block();
      send_request(random_request());
    end
    steady = 1'b0;
  endtask

  // Phases cover the register extremes, a divider of zero, a timeout of zero and a
  // divider lowered below a count built up in the phase before it.
  task automatic test_random_phases();
    run_random_phase(16'd1, 8'd255, 30, 1'b1);
    run_random_phase(16'd2, 8'd1, 30, 1'b0);
    run_random_phase(16'd12, 8'd4, 40, 1'b0);
    run_random_phase(16'd3, 8'd2, 30, 1'b0);
    run_random_phase(16'd0, 8'd0, 30, 1'b0);
    run_random_phase(16'd65535, 8'd255, 25, 1'b0);
    run_random_phase(16'd5, 8'd3, 30, 1'b0);
    run_random_phase(16'd1, 8'd1, 30, 1'b0);
  endtask

  initial begin
    monitor_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_basic_ops();
    test_full_table();
    test_random_phases();

    // Drain, then give the block time to show any stray result.
    settle_block();
    repeat (40) @(posedge clk);

    $display("tb: %0d requests and %0d results checked over %0d register settings",
             n_requests, n_results, n_settings);
    $display("tb: scans produced %0d pings and %0d timeouts; %0d mismatches",
             n_pings, n_timeouts, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
